FILE: hdl/url_query_decoder_assert.svh
// Assertion helpers for the RTL files, used by uqd_back.
`ifndef URL_QUERY_DECODER_ASSERT_SVH
`define URL_QUERY_DECODER_ASSERT_SVH

// Property checked on every rising edge outside reset.
`define UQD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true outside reset.
`define UQD_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: hdl/uqd_pkg.sv
// ----------------------------------------------------------------------------
// uqd_pkg
// Shared types and constants of the URL query decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package uqd_pkg;

  typedef enum logic [2:0] {
    KIND_PATH     = 3'd0,
    KIND_KEY      = 3'd1,
    KIND_VALUE    = 3'd2,
    KIND_PATH_END = 3'd3,
    KIND_PAIR_END = 3'd4,
    KIND_ERROR    = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_TRUNCATED = 3'd1,
    ERR_BAD_HEX   = 3'd2,
    ERR_NO_EQUALS = 3'd3,
    ERR_EMPTY_KEY = 3'd4
  } err_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    err_e       err;
  } result_t;

  // All results caused by one input byte.
  typedef struct packed {
    result_t first;
    result_t second;
    logic    two;
  } packet_t;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef logic [FIFO_AW-1:0] fifo_ptr_t;
  typedef logic [FIFO_AW:0]   fifo_cnt_t;

  localparam fifo_cnt_t FIFO_CNT_FULL = fifo_cnt_t'(FIFO_DEPTH);

endpackage

`default_nettype wire

FILE: hdl/uqd_front.sv
// ----------------------------------------------------------------------------
// uqd_front
// Parses one URL byte per cycle while accept_i is high and forms the packet of results it causes.
// ----------------------------------------------------------------------------
`default_nettype none

module uqd_front
  import uqd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       end_of_string_i,
  output packet_t         pkt_o,
  output logic            pkt_valid_o
);

  typedef enum logic [1:0] {PH_PATH, PH_KEY, PH_VALUE, PH_ERROR} phase_e;
  typedef enum logic [1:0] {ESC_NONE, ESC_HIGH, ESC_LOW} esc_e;

  localparam logic [7:0] CH_QUESTION = 8'h3F;
  localparam logic [7:0] CH_AMP      = 8'h26;
  localparam logic [7:0] CH_EQUALS   = 8'h3D;
  localparam logic [7:0] CH_PERCENT  = 8'h25;

  // {valid, nibble}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'b0_0000;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, 4'(c[2:0] + 3'd1) + 4'd8};
    end
    return r;
  endfunction

  phase_e     phase_q, phase_d, ph_mid;
  esc_e       esc_q, esc_d, esc_mid;
  logic [3:0] hn_q, hn_d, hn_mid;
  logic       kne_q, kne_d, kne_mid;

  logic       m_vld, e_vld, do_data;
  result_t    m_res, e_res;
  logic [4:0] hex;
  kind_e      data_kind;

  always_comb begin
    ph_mid    = phase_q;
    esc_mid   = esc_q;
    hn_mid    = hn_q;
    kne_mid   = kne_q;
    m_vld     = 1'b0;
    m_res     = '{kind: KIND_PATH, data: 8'h00, err: ERR_NONE};
    e_vld     = 1'b0;
    e_res     = '{kind: KIND_PATH, data: 8'h00, err: ERR_NONE};
    do_data   = 1'b0;
    hex       = hex_decode(in_byte_i);
    data_kind = (phase_q == PH_KEY) ? KIND_KEY : KIND_VALUE;

    unique case (phase_q)
      PH_PATH: begin
        m_vld = 1'b1;
        if (in_byte_i == CH_QUESTION) begin
          m_res.kind = KIND_PATH_END;
          ph_mid     = PH_KEY;
        end else begin
          m_res.data = in_byte_i;
        end
      end
      PH_KEY: begin
        if (in_byte_i == CH_AMP) begin
          m_vld = 1'b1;
          m_res = '{kind: KIND_ERROR, data: 8'h00, err: ERR_NO_EQUALS};
        end else if (in_byte_i == CH_EQUALS) begin
          if (esc_q != ESC_NONE) begin
            m_vld = 1'b1;
            m_res = '{kind: KIND_ERROR, data: 8'h00, err: ERR_TRUNCATED};
          end else if (!kne_q) begin
            m_vld = 1'b1;
            m_res = '{kind: KIND_ERROR, data: 8'h00, err: ERR_EMPTY_KEY};
          end else begin
            ph_mid = PH_VALUE;
          end
        end else begin
          kne_mid = 1'b1;
          do_data = 1'b1;
        end
      end
      PH_VALUE: begin
        if (in_byte_i == CH_AMP) begin
          m_vld = 1'b1;
          if (esc_q != ESC_NONE) begin
            m_res = '{kind: KIND_ERROR, data: 8'h00, err: ERR_TRUNCATED};
          end else begin
            m_res.kind = KIND_PAIR_END;
            ph_mid     = PH_KEY;
            kne_mid    = 1'b0;
          end
        end else begin
          do_data = 1'b1;
        end
      end
      PH_ERROR: begin
      end
      default: begin
      end
    endcase

    if (do_data) begin
      if (esc_q == ESC_NONE) begin
        if (in_byte_i == CH_PERCENT) begin
          esc_mid = ESC_HIGH;
        end else begin
          m_vld = 1'b1;
          m_res = '{kind: data_kind, data: in_byte_i, err: ERR_NONE};
        end
      end else if (!hex[4]) begin
        m_vld = 1'b1;
        m_res = '{kind: KIND_ERROR, data: 8'h00, err: ERR_BAD_HEX};
      end else if (esc_q == ESC_HIGH) begin
        hn_mid  = hex[3:0];
        esc_mid = ESC_LOW;
      end else begin
        m_vld   = 1'b1;
        m_res   = '{kind: data_kind, data: {hn_q, hex[3:0]}, err: ERR_NONE};
        esc_mid = ESC_NONE;
      end
    end

    if (m_vld && m_res.kind == KIND_ERROR) begin
      ph_mid  = PH_ERROR;
      esc_mid = ESC_NONE;
    end

    if (end_of_string_i) begin
      unique case (ph_mid)
        PH_PATH: begin
          e_vld      = 1'b1;
          e_res.kind = KIND_PATH_END;
        end
        PH_KEY: begin
          // '?' on the final byte leaves an empty query
          if (phase_q != PH_PATH) begin
            e_vld = 1'b1;
            e_res = '{kind: KIND_ERROR, data: 8'h00, err: ERR_NO_EQUALS};
          end
        end
        PH_VALUE: begin
          e_vld = 1'b1;
          if (esc_mid != ESC_NONE) begin
            e_res = '{kind: KIND_ERROR, data: 8'h00, err: ERR_TRUNCATED};
          end else begin
            e_res.kind = KIND_PAIR_END;
          end
        end
        PH_ERROR: begin
        end
        default: begin
        end
      endcase
      phase_d = PH_PATH;
      esc_d   = ESC_NONE;
      hn_d    = 4'h0;
      kne_d   = 1'b0;
    end else begin
      phase_d = ph_mid;
      esc_d   = esc_mid;
      hn_d    = hn_mid;
      kne_d   = kne_mid;
    end

    if (m_vld) begin
      pkt_o.first  = m_res;
      pkt_o.second = e_res;
      pkt_o.two    = e_vld;
    end else begin
      pkt_o.first  = e_res;
      pkt_o.second = e_res;
      pkt_o.two    = 1'b0;
    end
    pkt_valid_o = accept_i && (m_vld || e_vld);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_PATH;
      esc_q   <= ESC_NONE;
      hn_q    <= 4'h0;
      kne_q   <= 1'b0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      esc_q   <= esc_d;
      hn_q    <= hn_d;
      kne_q   <= kne_d;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/uqd_fifo.sv
// ----------------------------------------------------------------------------
// uqd_fifo
// Short packet queue between the parser and the result serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module uqd_fifo
  import uqd_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    wr_en_i,
  input  wire packet_t wr_pkt_i,
  input  wire logic    rd_en_i,
  output packet_t      rd_pkt_o,
  output logic         full_o,
  output logic         empty_o
);

  packet_t   mem_q [FIFO_DEPTH];
  fifo_ptr_t wr_ptr_q, rd_ptr_q;
  fifo_cnt_t cnt_q;

  assign rd_pkt_o = mem_q[rd_ptr_q];
  assign full_o   = (cnt_q == FIFO_CNT_FULL);
  assign empty_o  = (cnt_q == '0);

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wr_pkt_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_en_i) begin
        wr_ptr_q <= wr_ptr_q + fifo_ptr_t'(1);
      end
      if (rd_en_i) begin
        rd_ptr_q <= rd_ptr_q + fifo_ptr_t'(1);
      end
      if (wr_en_i && !rd_en_i) begin
        cnt_q <= cnt_q + fifo_cnt_t'(1);
      end else if (!wr_en_i && rd_en_i) begin
        cnt_q <= cnt_q - fifo_cnt_t'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/uqd_back.sv
// ----------------------------------------------------------------------------
// uqd_back
// Serializes queued packets into single result transactions.
// ----------------------------------------------------------------------------
`default_nettype none

`include "url_query_decoder_assert.svh"

module uqd_back
  import uqd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire packet_t     head_i,
  input  wire logic        head_empty_i,
  output logic             head_rd_o,
  input  wire logic        pop,
  output logic             empty,
  output logic [2:0]       kind_o,
  output logic [7:0]       out_byte_o,
  output logic [2:0]       error_code_o,
  output logic             last_of_run_o
);

  logic    sel_q, sel_d;
  result_t res;
  logic    take;
  logic    take_first;
  logic    res_is_data;

  assign res           = sel_q ? head_i.second : head_i.first;
  assign empty         = head_empty_i;
  assign kind_o        = res.kind;
  assign out_byte_o    = res.data;
  assign error_code_o  = res.err;
  assign last_of_run_o = sel_q || !head_i.two;

  assign take      = pop && !head_empty_i;
  assign head_rd_o = take && (sel_q || !head_i.two);

  assign take_first  = take && !sel_q && head_i.two;
  assign res_is_data = res.kind inside {KIND_PATH, KIND_KEY, KIND_VALUE};

  always_comb begin
    sel_d = sel_q;
    if (take) begin
      sel_d = !head_rd_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= 1'b0;
    end else begin
      sel_q <= sel_d;
    end
  end

  `UQD_ASSERT(a_sel_two, clk_i, rst_ni, sel_q |-> (head_i.two && !head_empty_i), "bad select")
  `UQD_ASSERT(a_first_then_second, clk_i, rst_ni, take_first |=> (sel_q && !empty), "lost second")
  `UQD_ASSERT(a_second_kind, clk_i, rst_ni, sel_q |-> !res_is_data, "second result is data")
  `UQD_ASSERT_NEVER(a_mark_data, clk_i, rst_ni, !empty && !res_is_data && |res.data, "marker data")

endmodule

`default_nettype wire

FILE: hdl/url_query_decoder.sv
// Results leave the head of a registered packet queue in byte order. Throughput: one
// byte per cycle in while full is low; one result transaction per cycle out while
// pop is high and empty is low, so a byte with two results takes two pops. A four-entry
// packet queue sets how far input may run ahead of a stalled output before full rises.
// Reset (rst_ni low, asynchronous) returns the parser to the path and empties the queue.
// ----------------------------------------------------------------------------
// url_query_decoder
// Splits a URL into path, key and value bytes, percent-decoding keys and values.
// ----------------------------------------------------------------------------
`default_nettype none

module url_query_decoder
  import uqd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       end_of_string_i,
  output logic            empty,
  input  wire logic       pop,
  output logic [2:0]      kind_o,
  output logic [7:0]      out_byte_o,
  output logic [2:0]      error_code_o,
  output logic            last_of_run_o
);

  logic    accept;
  packet_t pkt, head;
  logic    pkt_valid, head_empty, head_rd;

  assign accept = push && !full;

  uqd_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .in_byte_i       (in_byte_i),
    .end_of_string_i (end_of_string_i),
    .pkt_o           (pkt),
    .pkt_valid_o     (pkt_valid)
  );

  uqd_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (pkt_valid),
    .wr_pkt_i (pkt),
    .rd_en_i  (head_rd),
    .rd_pkt_o (head),
    .full_o   (full),
    .empty_o  (head_empty)
  );

  uqd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .head_empty_i  (head_empty),
    .head_rd_o     (head_rd),
    .pop           (pop),
    .empty         (empty),
    .kind_o        (kind_o),
    .out_byte_o    (out_byte_o),
    .error_code_o  (error_code_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

`default_nettype wire

FILE: sim/url_query_decoder_tb.sv
// ----------------------------------------------------------------------------
// url_query_decoder_tb
// Self-checking bench for the URL query decoder. A scoreboard predicts the
// path, key, value, marker and error transactions of every accepted byte and
// checks them in order against the output queue. Directed strings cover the
// corner cases; random strings (mostly well-formed, some broken, some noise)
// run under several sender/receiver throttling mixes and one long output hold.
// ----------------------------------------------------------------------------
`default_nettype none

module url_query_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import uqd_pkg::*;

  localparam logic [7:0] CH_QUERY = "?";
  localparam logic [7:0] CH_AMP   = "&";
  localparam logic [7:0] CH_EQ    = "=";
  localparam logic [7:0] CH_PCT   = "%";

  typedef logic [7:0] text_t[$];

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    err_e       err;
    logic       run_end;
  } decoded_t;

  class query_scoreboard;
    typedef enum logic [1:0] {ST_PATH, ST_KEY, ST_VALUE, ST_SKIP} parse_e;

    parse_e     st;
    logic [1:0] esc;
    logic [3:0] hi;
    bit         key_seen;
    bit         pair_busy;
    bit         query_seen;
    decoded_t   step_q[$];
    decoded_t   pending_q[$];
    int         errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      st         = ST_PATH;
      esc        = 2'd0;
      hi         = 4'd0;
      key_seen   = 1'b0;
      pair_busy  = 1'b0;
      query_seen = 1'b0;
    endfunction

    task report(string what);
      errors++;
      if (errors <= 100) $display("%0t mismatch: %s", $time, what);
    endtask

    function void emit(kind_e k, logic [7:0] d, err_e e);
      if (step_q.size() < 2) step_q.push_back('{k, d, e, 1'b0});
    endfunction

    function void raise_error(err_e e);
      emit(KIND_ERROR, 8'h00, e);
      st  = ST_SKIP;
      esc = 2'd0;
    endfunction

    function int hex_value(logic [7:0] b);
      if (b >= "0" && b <= "9") return int'(b - "0");
      if (b >= "a" && b <= "f") return int'(b - "a") + 10;
      if (b >= "A" && b <= "F") return int'(b - "A") + 10;
      return -1;
    endfunction

    function void take_data(logic [7:0] b, kind_e k);
      int v;
      if (esc == 2'd0) begin
        if (b == CH_PCT) esc = 2'd1;
        else emit(k, b, ERR_NONE);
        return;
      end
      v = hex_value(b);
      if (v < 0) begin
        raise_error(ERR_BAD_HEX);
        return;
      end
      if (esc == 2'd1) begin
        hi  = v[3:0];
        esc = 2'd2;
      end else begin
        emit(k, {hi, v[3:0]}, ERR_NONE);
        esc = 2'd0;
      end
    endfunction

    // Returns 1 when the byte was parsed rather than skipped after an error.
    function bit note_byte(logic [7:0] b, bit eos);
      bit taken;
      taken = (st != ST_SKIP);
      step_q.delete();
      case (st)
        ST_PATH: begin
          if (b == CH_QUERY) begin
            emit(KIND_PATH_END, 8'h00, ERR_NONE);
            st = ST_KEY;
          end else begin
            emit(KIND_PATH, b, ERR_NONE);
          end
        end
        ST_KEY: begin
          query_seen = 1'b1;
          pair_busy  = 1'b1;
          if (b == CH_AMP) begin
            raise_error(ERR_NO_EQUALS);
          end else if (b == CH_EQ) begin
            if (esc != 2'd0) raise_error(ERR_TRUNCATED);
            else if (!key_seen) raise_error(ERR_EMPTY_KEY);
            else st = ST_VALUE;
          end else begin
            key_seen = 1'b1;
            take_data(b, KIND_KEY);
          end
        end
        ST_VALUE: begin
          query_seen = 1'b1;
          pair_busy  = 1'b1;
          if (b == CH_AMP) begin
            if (esc != 2'd0) begin
              raise_error(ERR_TRUNCATED);
            end else begin
              emit(KIND_PAIR_END, 8'h00, ERR_NONE);
              st        = ST_KEY;
              key_seen  = 1'b0;
              pair_busy = 1'b0;
            end
          end else begin
            take_data(b, KIND_VALUE);
          end
        end
        default: ;
      endcase
      if (eos) begin
        case (st)
          ST_PATH: emit(KIND_PATH_END, 8'h00, ERR_NONE);
          ST_KEY: if (query_seen || pair_busy) raise_error(ERR_NO_EQUALS);
          ST_VALUE: begin
            if (esc != 2'd0) raise_error(ERR_TRUNCATED);
            else emit(KIND_PAIR_END, 8'h00, ERR_NONE);
          end
          default: ;
        endcase
        restart();
      end
      if (step_q.size() > 0) step_q[step_q.size()-1].run_end = 1'b1;
      foreach (step_q[i]) pending_q.push_back(step_q[i]);
      return taken;
    endfunction

    task check_result(logic [2:0] k, logic [7:0] d, logic [2:0] e, logic l);
      decoded_t exp;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected transaction kind=%0d data=%h", k, d));
        return;
      end
      exp = pending_q.pop_front();
      if (k !== exp.kind) report($sformatf("kind got %0d want %0d", k, exp.kind));
      if (d !== exp.data) report($sformatf("out_byte got %h want %h", d, exp.data));
      if (e !== exp.err) report($sformatf("error_code got %0d want %0d", e, exp.err));
      if (l !== exp.run_end) report($sformatf("last_of_run got %b want %b", l, exp.run_end));
    endtask
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       push;
  logic       full;
  logic [7:0] in_byte_i;
  logic       end_of_string_i;
  logic       empty;
  logic       pop;
  logic [2:0] kind_o;
  logic [7:0] out_byte_o;
  logic [2:0] error_code_o;
  logic       last_of_run_o;

  query_scoreboard sb = new();
  int  sent = 0;
  int  idle_pct = 0;
  int  stall_pct = 0;
  bit  hold_go = 1'b0;
  logic hold_off;

  url_query_decoder dut (.*);

  always #5ns clk_i = ~clk_i;

  task automatic send_byte(logic [7:0] b, bit eos);
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push            <= 1'b1;
    in_byte_i       <= b;
    end_of_string_i <= eos;
    do @(posedge clk_i); while (full !== 1'b0);
    if (sb.note_byte(b, eos)) sent++;
  endtask

  task automatic send_seq(text_t s);
    for (int i = 0; i < s.size(); i++) send_byte(s[i], i == s.size() - 1);
  endtask

  task automatic send_str(string t);
    text_t s;
    for (int i = 0; i < t.len(); i++) s.push_back(t[i]);
    send_seq(s);
  endtask

  task automatic drain();
    push <= 1'b0;
    do @(posedge clk_i); while (sb.pending_q.size() != 0);
  endtask

  function automatic logic [7:0] hex_char(int unsigned v, bit lower);
    if (v < 10) return 8'("0" + v);
    return lower ? 8'("a" + v - 10) : 8'("A" + v - 10);
  endfunction

  function automatic void add_field(ref text_t s, input int unsigned n, input bit allow_eq);
    logic [7:0] c;
    repeat (n) begin
      if ($urandom_range(3) == 0) begin
        s.push_back(CH_PCT);
        s.push_back(hex_char($urandom_range(15), 1'($urandom_range(1))));
        s.push_back(hex_char($urandom_range(15), 1'($urandom_range(1))));
      end else begin
        do c = 8'($urandom_range(255));
        while (c == CH_AMP || c == CH_PCT || (c == CH_EQ && !allow_eq));
        s.push_back(c);
      end
    end
  endfunction

  function automatic text_t well_formed();
    text_t       s;
    logic [7:0]  c;
    int unsigned np;
    repeat ($urandom_range(5)) begin
      do c = 8'($urandom_range(255)); while (c == CH_QUERY);
      s.push_back(c);
    end
    if ($urandom_range(3) != 0) begin
      s.push_back(CH_QUERY);
      np = $urandom_range(3);
      for (int i = 0; i < np; i++) begin
        if (i > 0) s.push_back(CH_AMP);
        add_field(s, $urandom_range(1, 3), 1'b0);
        s.push_back(CH_EQ);
        add_field(s, $urandom_range(0, 4), 1'b1);
      end
    end
    if (s.size() == 0) s.push_back("/");
    return s;
  endfunction

  function automatic text_t broken();
    text_t       s;
    logic [7:0]  marks[4];
    int unsigned p;
    marks = '{CH_PCT, CH_AMP, CH_EQ, CH_QUERY};
    s = well_formed();
    p = $urandom_range(s.size() - 1);
    case ($urandom_range(3))
      0: s[p] = marks[2'($urandom_range(3))];
      1: s.insert(p, marks[2'($urandom_range(3))]);
      2: s = s[0:p];
      default: begin
        s.push_back(CH_PCT);
        if ($urandom_range(1)) begin
          s.push_back(hex_char($urandom_range(15), 1'($urandom_range(1))));
        end
      end
    endcase
    return s;
  endfunction

  function automatic text_t noise();
    text_t s;
    repeat ($urandom_range(1, 8)) s.push_back(8'($urandom_range(255)));
    return s;
  endfunction

  task automatic send_random(int target);
    int unsigned r;
    while (sent < target) begin
      r = $urandom_range(99);
      if (r < 70) send_seq(well_formed());
      else if (r < 85) send_seq(broken());
      else send_seq(noise());
    end
  endtask

  // long output hold while the input keeps pushing
  initial begin
    hold_off = 1'b0;
    wait (hold_go);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin
    pop = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && pop && empty === 1'b0)
        sb.check_result(kind_o, out_byte_o, error_code_o, last_of_run_o);
      pop <= !hold_off && ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    int unsigned idle_mix[4];
    int unsigned stall_mix[4];
    idle_mix  = '{0, 67, 0, 28};
    stall_mix = '{0, 0, 67, 28};
    rst_ni          = 1'b0;
    push            = 1'b0;
    in_byte_i       = 8'h00;
    end_of_string_i = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_str("\377");
    send_str("?");
    send_str("?a=%4F&");
    send_str("?=");
    send_str("?%F=");
    send_str("?&");
    send_str("?k%");
    send_str("?k=%");
    send_str("?%?");
    drain();

    hold_go = 1'b1;
    send_random(sent + 150);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = idle_mix[ph];
      stall_pct = stall_mix[ph];
      send_random(sent + 300);
      drain();
    end

    repeat (10) @(posedge clk_i);
    if (sb.errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #5ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
+incdir+hdl
hdl/uqd_pkg.sv
hdl/uqd_front.sv
hdl/uqd_fifo.sv
hdl/uqd_back.sv
hdl/url_query_decoder.sv
sim/url_query_decoder_tb.sv
